### rtl/gic_pkg.sv
// ----------------------------------------------------------------------------
// gic_pkg - shared types and constants of the GPIO interrupt controller
// Register indexes, operation and trigger codes, beat payloads and the
// control/status records that the pin lanes receive and hand to the merge stage.
// ----------------------------------------------------------------------------
package gic_pkg;

   localparam int unsigned DATA_BITS     = 32;
   localparam int unsigned MAX_PINS      = 32;
   localparam int unsigned PINS_PER_WORD = 8;
   localparam int unsigned FIELD_BITS    = 4;
   localparam int unsigned TRIG_BITS     = 3;
   localparam int unsigned CFG_WORDS     = 4;

   // operation codes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // register indexes
   localparam logic [2:0] REG_CFG_LAST = 3'd3;
   localparam logic [2:0] REG_ENABLE   = 3'd4;
   localparam logic [2:0] REG_PENDING  = 3'd5;
   localparam logic [2:0] REG_DEBOUNCE = 3'd6;

   // trigger codes; the remaining codes disable detection
   localparam logic [2:0] TRIG_RISE = 3'd0;
   localparam logic [2:0] TRIG_FALL = 3'd1;
   localparam logic [2:0] TRIG_HIGH = 3'd2;
   localparam logic [2:0] TRIG_LOW  = 3'd3;
   localparam logic [2:0] TRIG_BOTH = 3'd4;

   typedef struct packed {
      logic [1:0]           operation;
      logic [2:0]           reg_index;
      logic [DATA_BITS-1:0] write_data;
      logic [DATA_BITS-1:0] pin_levels;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] read_data;
      logic                 irq_line;
   } rsp_payload_type;

   // per-beat control broadcast to every lane
   typedef struct packed {
      logic       write;
      logic       tick;
      logic [2:0] reg_index;
   } lane_ctl_type;

   // lane state seen by the merge stage
   typedef struct packed {
      logic [TRIG_BITS-1:0] trig;
      logic                 enable;
      logic                 pending;
      logic                 irq;      // pending and enable after this beat
   } lane_stat_type;

endpackage

### rtl/gic_chan_if.sv
// ----------------------------------------------------------------------------
// gic_chan_if - valid/ready channel
// Carries one payload per beat; a beat moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface gic_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/gic_lane.sv
// ----------------------------------------------------------------------------
// gic_lane - per-pin trigger detector
// Holds one pin's trigger type, enable, pending and previous level, and
// updates them for register writes and sample ticks.
// ----------------------------------------------------------------------------
module gic_lane #(
   parameter int unsigned LANE_IDX = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gic_pkg::lane_ctl_type             ctl,
   input  logic [gic_pkg::DATA_BITS-1:0]     write_data,
   input  logic                              level,
   output gic_pkg::lane_stat_type            stat
);

   localparam logic [2:0] CFG_WORD =
      3'(LANE_IDX / gic_pkg::PINS_PER_WORD);
   localparam int unsigned FIELD_LSB =
      (LANE_IDX % gic_pkg::PINS_PER_WORD) * gic_pkg::FIELD_BITS;

   logic [gic_pkg::TRIG_BITS-1:0] trig_ff, trig_in;
   logic                          enable_ff, enable_in;
   logic                          pending_ff, pending_in;
   logic                          prev_ff, prev_in;
   logic                          rise, fall, hit;

   assign rise = level & ~prev_ff;
   assign fall = ~level & prev_ff;

   always_comb begin
      unique case (trig_ff)
         gic_pkg::TRIG_RISE: hit = rise;
         gic_pkg::TRIG_FALL: hit = fall;
         gic_pkg::TRIG_HIGH: hit = level;
         gic_pkg::TRIG_LOW:  hit = ~level;
         gic_pkg::TRIG_BOTH: hit = rise | fall;
         default:            hit = 1'b0;
      endcase
   end

   always_comb begin
      trig_in    = trig_ff;
      enable_in  = enable_ff;
      pending_in = pending_ff;
      prev_in    = prev_ff;
      if (ctl.write) begin
         if (ctl.reg_index == CFG_WORD)
            trig_in = write_data[FIELD_LSB +: gic_pkg::TRIG_BITS];
         if (ctl.reg_index == gic_pkg::REG_ENABLE)
            enable_in = write_data[LANE_IDX];
         if (ctl.reg_index == gic_pkg::REG_PENDING)
            pending_in = pending_ff & ~write_data[LANE_IDX];
      end
      if (ctl.tick) begin
         pending_in = pending_ff | hit;
         prev_in    = level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff    <= gic_pkg::TRIG_RISE;
         enable_ff  <= 1'b0;
         pending_ff <= 1'b0;
         prev_ff    <= 1'b0;
      end else begin
         trig_ff    <= trig_in;
         enable_ff  <= enable_in;
         pending_ff <= pending_in;
         prev_ff    <= prev_in;
      end
   end

   assign stat.trig    = trig_ff;
   assign stat.enable  = enable_ff;
   assign stat.pending = pending_ff;
   assign stat.irq     = pending_in & enable_in;

endmodule

### rtl/gic_merge.sv
// ----------------------------------------------------------------------------
// gic_merge - lane merge and result register
// Gathers the lanes into register words, ORs the interrupt requests and
// holds the result beat until the sink takes it.
// ----------------------------------------------------------------------------
module gic_merge #(
   parameter int unsigned NUM_PINS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gic_pkg::lane_stat_type            stat [NUM_PINS],
   input  logic                              accept,
   input  logic [1:0]                        operation,
   input  logic [2:0]                        reg_index,
   input  logic [gic_pkg::DATA_BITS-1:0]     debounce,
   output logic                              in_ready,
   input  logic                              out_ready,
   output logic                              out_valid,
   output gic_pkg::rsp_payload_type          out_payload
);

   logic [gic_pkg::DATA_BITS-1:0] cfg_word [gic_pkg::CFG_WORDS];
   logic [gic_pkg::DATA_BITS-1:0] enable_vec, pending_vec, rdata;
   logic [NUM_PINS-1:0]           irq_vec;
   logic                          valid_ff, valid_in;
   gic_pkg::rsp_payload_type      payload_ff, payload_in;

   always_comb begin
      for (int w = 0; w < gic_pkg::CFG_WORDS; w++)
         cfg_word[w] = '0;
      enable_vec  = '0;
      pending_vec = '0;
      for (int p = 0; p < NUM_PINS; p++) begin
         cfg_word[p / gic_pkg::PINS_PER_WORD]
            [(p % gic_pkg::PINS_PER_WORD) * gic_pkg::FIELD_BITS +: gic_pkg::TRIG_BITS]
            = stat[p].trig;
         enable_vec[p]  = stat[p].enable;
         pending_vec[p] = stat[p].pending;
         irq_vec[p]     = stat[p].irq;
      end
   end

   always_comb begin
      rdata = '0;
      if (operation == gic_pkg::OP_READ) begin
         priority if (reg_index <= gic_pkg::REG_CFG_LAST)
            rdata = cfg_word[reg_index[1:0]];
         else if (reg_index == gic_pkg::REG_ENABLE)
            rdata = enable_vec;
         else if (reg_index == gic_pkg::REG_PENDING)
            rdata = pending_vec;
         else if (reg_index == gic_pkg::REG_DEBOUNCE)
            rdata = debounce;
      end
   end

   assign in_ready = ~valid_ff | out_ready;

   always_comb begin
      payload_in = payload_ff;
      valid_in   = valid_ff & ~out_ready;
      if (accept) begin
         payload_in.read_data = rdata;
         payload_in.irq_line  = |irq_vec;
         valid_in             = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      payload_ff <= payload_in;
   end

   assign out_valid   = valid_ff;
   assign out_payload = payload_ff;

endmodule

### rtl/gpio_interrupt_controller.sv
// ----------------------------------------------------------------------------
// gpio_interrupt_controller - 32-bit register mapped GPIO interrupt block
// Trigger configuration, enable, write-one-to-clear pending and a stored
// debounce word, driven by read, write and pin sample beats.
// ----------------------------------------------------------------------------
// Each request beat is a register read, a register write or a pin sample
// tick, and every request yields exactly one response beat carrying the
// read data (zero unless it is a read) and the interrupt line as it stands
// after that beat. The block takes one beat per clock: state is updated at
// the accepting edge and the response is registered in a single output
// register at that same edge, so throughput stays one beat per clock
// as long as the sink keeps ready high. When the response register is full
// and the sink stalls, request ready drops until the response is taken.
// One lane per pin (NUM_PINS lanes) holds the trigger type, enable, pending
// and previous level; the merge stage assembles register words and ORs the
// lane interrupts. Pins at or above NUM_PINS read as zero everywhere.
// Pending bits latch whatever the enable mask holds, and a level-mode pin
// re-arms its pending bit on every tick while its level persists.
// ----------------------------------------------------------------------------
module gpio_interrupt_controller #(
   parameter int unsigned NUM_PINS = 32
) (
   input logic       clock,
   input logic       reset,
   gic_chan_if.sink   req_chan,
   gic_chan_if.source rsp_chan
);

   gic_pkg::lane_ctl_type         lane_ctl;
   gic_pkg::lane_stat_type        lane_stat [NUM_PINS];
   gic_pkg::req_payload_type      req;
   gic_pkg::rsp_payload_type      rsp;
   logic                          accept;
   logic                          in_ready;
   logic [gic_pkg::DATA_BITS-1:0] debounce_ff, debounce_in;

   assign req    = req_chan.payload;
   assign accept = req_chan.valid & in_ready;
   assign req_chan.ready = in_ready;

   // broadcast the decoded beat to all lanes
   assign lane_ctl.write     = accept & (req.operation == gic_pkg::OP_WRITE);
   assign lane_ctl.tick      = accept & (req.operation == gic_pkg::OP_TICK);
   assign lane_ctl.reg_index = req.reg_index;

   // debounce word: stored and read back only
   always_comb begin
      debounce_in = debounce_ff;
      if (lane_ctl.write && req.reg_index == gic_pkg::REG_DEBOUNCE)
         debounce_in = req.write_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= '0;
      end else begin
         debounce_ff <= debounce_in;
      end
   end

   // one detector per pin
   for (genvar p = 0; p < NUM_PINS; p++) begin : g_lane
      gic_lane #(
         .LANE_IDX (p)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctl        (lane_ctl),
         .write_data (req.write_data),
         .level      (req.pin_levels[p]),
         .stat       (lane_stat[p])
      );
   end

   // merge lanes, build the response and hold it for the sink
   gic_merge #(
      .NUM_PINS (NUM_PINS)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .stat        (lane_stat),
      .accept      (accept),
      .operation   (req.operation),
      .reg_index   (req.reg_index),
      .debounce    (debounce_ff),
      .in_ready    (in_ready),
      .out_ready   (rsp_chan.ready),
      .out_valid   (rsp_chan.valid),
      .out_payload (rsp)
   );

   assign rsp_chan.payload = rsp;

endmodule
